@@ sv/versatile_interface_adapter_assert.svh @@
// Assertion macros for the port-level checker of the interface adapter.
`ifndef VERSATILE_INTERFACE_ADAPTER_ASSERT_SVH
`define VERSATILE_INTERFACE_ADAPTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define VIA_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define VIA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define VIA_ASSERT_ALWAYS_NEXT(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

@@ sv/vai_pkg.sv @@
// ----------------------------------------------------------------------------
// vai_pkg
// Item types, register map and flag positions of the interface adapter.
// ----------------------------------------------------------------------------
package vai_pkg;

   typedef struct packed {
      logic [2:0] mode;
      logic [3:0] reg_addr;
      logic [7:0] write_data;
      logic [1:0] line_select;
      logic       port_select;
      logic [7:0] port_mask;
      logic       tick_cycles;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq;
      logic [7:0] port_a_out;
      logic [7:0] port_b_out;
      logic       ca2_level;
      logic       cb1_level;
      logic       cb2_level;
   } rsp_type;

   // item kinds
   localparam logic [2:0] MODE_WRITE = 3'd0;
   localparam logic [2:0] MODE_READ  = 3'd1;
   localparam logic [2:0] MODE_TICK  = 3'd2;
   localparam logic [2:0] MODE_LINE  = 3'd3;
   localparam logic [2:0] MODE_PORT  = 3'd4;

   // register map
   localparam logic [3:0] REG_ORB   = 4'd0;
   localparam logic [3:0] REG_ORA   = 4'd1;
   localparam logic [3:0] REG_DDRB  = 4'd2;
   localparam logic [3:0] REG_DDRA  = 4'd3;
   localparam logic [3:0] REG_T1CL  = 4'd4;
   localparam logic [3:0] REG_T1CH  = 4'd5;
   localparam logic [3:0] REG_T1LL  = 4'd6;
   localparam logic [3:0] REG_T1LH  = 4'd7;
   localparam logic [3:0] REG_T2CL  = 4'd8;
   localparam logic [3:0] REG_T2CH  = 4'd9;
   localparam logic [3:0] REG_SR    = 4'd10;
   localparam logic [3:0] REG_ACR   = 4'd11;
   localparam logic [3:0] REG_PCR   = 4'd12;
   localparam logic [3:0] REG_IFR   = 4'd13;
   localparam logic [3:0] REG_IER   = 4'd14;
   localparam logic [3:0] REG_ORANH = 4'd15;

   // control lines
   localparam logic [1:0] LINE_CA1 = 2'd0;
   localparam logic [1:0] LINE_CA2 = 2'd1;
   localparam logic [1:0] LINE_CB1 = 2'd2;
   localparam logic [1:0] LINE_CB2 = 2'd3;

   // flag bits
   localparam int unsigned FL_CA2 = 0;
   localparam int unsigned FL_CA1 = 1;
   localparam int unsigned FL_SR  = 2;
   localparam int unsigned FL_CB2 = 3;
   localparam int unsigned FL_CB1 = 4;
   localparam int unsigned FL_T2  = 5;
   localparam int unsigned FL_T1  = 6;

   // run bits
   localparam int unsigned RF_T1RUN = 0;
   localparam int unsigned RF_T2RUN = 1;
   localparam int unsigned RF_T1RLD = 2;
   localparam int unsigned RF_CA2P  = 3;
   localparam int unsigned RF_CB2P  = 4;

   // shift modes (ACR bits 4:2)
   localparam logic [2:0] SM_FREE  = 3'b100;
   localparam logic [2:0] SM_T2OUT = 3'b101;
   localparam logic [2:0] SM_PHI2  = 3'b110;

   // handshake modes (PCR CA2 bits 3:1, CB2 bits 7:5)
   localparam logic [2:0] HS_IN_NEG  = 3'b000;
   localparam logic [2:0] HS_IN_POS  = 3'b010;
   localparam logic [2:0] HS_OUT_HS  = 3'b100;
   localparam logic [2:0] HS_OUT_PLS = 3'b101;
   localparam logic [2:0] HS_OUT_LOW = 3'b110;
   localparam logic [2:0] HS_OUT_HI  = 3'b111;

   localparam logic [3:0] SR_FULL = 4'd8;

endpackage

@@ sv/vai_core.sv @@
// ----------------------------------------------------------------------------
// vai_core
// Register file, timers, shift register and handshake logic of the adapter.
// Applies one item per enabled cycle and shows the result it produces.
// ----------------------------------------------------------------------------
module vai_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  vai_pkg::req_type req,
   output vai_pkg::rsp_type rsp
);
   import vai_pkg::*;

   logic [7:0]  out_a_ff, out_a_in, out_b_ff, out_b_in;
   logic [7:0]  dir_a_ff, dir_a_in, dir_b_ff, dir_b_in;
   logic [7:0]  in_a_ff, in_a_in, in_b_ff, in_b_in;
   logic [7:0]  lat_a_ff, lat_a_in, lat_b_ff, lat_b_in;
   logic [15:0] t1_latch_ff, t1_latch_in, t1_count_ff, t1_count_in;
   logic [15:0] t2_latch_ff, t2_latch_in, t2_count_ff, t2_count_in;
   logic [7:0]  sr_data_ff, sr_data_in, acr_ff, acr_in, pcr_ff, pcr_in;
   logic [6:0]  ifr_ff, ifr_in, ier_ff, ier_in;
   logic [3:0]  lines_ff, lines_in;
   logic [4:0]  run_ff, run_in;
   logic [3:0]  sr_count_ff, sr_count_in;
   logic [8:0]  sr_timer_ff, sr_timer_in;
   logic [7:0]  rd;

   // Compute the next state for the item at the input
   always_comb begin
      logic        lv, old, stop, falling;
      logic [2:0]  hs;
      logic [8:0]  reload;
      logic signed [10:0] t;
      out_a_in = out_a_ff;   out_b_in = out_b_ff;
      dir_a_in = dir_a_ff;   dir_b_in = dir_b_ff;
      in_a_in = in_a_ff;     in_b_in = in_b_ff;
      lat_a_in = lat_a_ff;   lat_b_in = lat_b_ff;
      t1_latch_in = t1_latch_ff; t1_count_in = t1_count_ff;
      t2_latch_in = t2_latch_ff; t2_count_in = t2_count_ff;
      sr_data_in = sr_data_ff; acr_in = acr_ff; pcr_in = pcr_ff;
      ifr_in = ifr_ff; ier_in = ier_ff; lines_in = lines_ff; run_in = run_ff;
      sr_count_in = sr_count_ff; sr_timer_in = sr_timer_ff;
      rd = 8'h00;
      lv = req.write_data[0];
      old = 1'b0; stop = 1'b0; falling = 1'b0;
      hs = 3'b000;
      reload = {1'b0, t2_latch_ff[7:0]} + 9'd1;
      t = '0;

      unique case (req.mode)
         MODE_WRITE, MODE_READ: begin
            if (req.mode == MODE_READ) begin
               case (req.reg_addr)
                  REG_ORB:  rd = (out_b_ff & dir_b_ff) | (lat_b_ff & ~dir_b_ff);
                  REG_ORA, REG_ORANH:
                     rd = (out_a_ff & dir_a_ff) | (lat_a_ff & ~dir_a_ff);
                  REG_DDRB: rd = dir_b_ff;
                  REG_DDRA: rd = dir_a_ff;
                  REG_T1CL: rd = t1_count_ff[7:0];
                  REG_T1CH: rd = t1_count_ff[15:8];
                  REG_T1LL: rd = t1_latch_ff[7:0];
                  REG_T1LH: rd = t1_latch_ff[15:8];
                  REG_T2CL: rd = t2_count_ff[7:0];
                  REG_T2CH: rd = t2_count_ff[15:8];
                  REG_SR:   rd = sr_data_ff;
                  REG_ACR:  rd = acr_ff;
                  REG_PCR:  rd = pcr_ff;
                  REG_IFR:  rd = {|(ifr_ff & ier_ff), ifr_ff};
                  default:  rd = {1'b1, ier_ff};
               endcase
            end
            // register side effects
            case (req.reg_addr)
               REG_ORB, REG_ORA: begin
                  if (req.reg_addr == REG_ORB) begin
                     if (req.mode == MODE_WRITE) out_b_in = req.write_data;
                     lat_b_in = in_b_ff;
                     ifr_in[FL_CB1] = 1'b0;
                     hs = pcr_ff[7:5];
                     case (hs)
                        HS_IN_NEG, HS_IN_POS: ifr_in[FL_CB2] = 1'b0;
                        HS_OUT_PLS: begin
                           run_in[RF_CB2P] = 1'b1;
                           lines_in[LINE_CB2] = 1'b0;
                        end
                        HS_OUT_HS: lines_in[LINE_CB2] = 1'b0;
                        default: ;
                     endcase
                  end else begin
                     if (req.mode == MODE_WRITE) out_a_in = req.write_data;
                     lat_a_in = in_a_ff;
                     ifr_in[FL_CA1] = 1'b0;
                     hs = pcr_ff[3:1];
                     case (hs)
                        HS_IN_NEG, HS_IN_POS: ifr_in[FL_CA2] = 1'b0;
                        HS_OUT_PLS: begin
                           run_in[RF_CA2P] = 1'b1;
                           lines_in[LINE_CA2] = 1'b0;
                        end
                        HS_OUT_HS: lines_in[LINE_CA2] = 1'b0;
                        default: ;
                     endcase
                  end
               end
               REG_DDRB: if (req.mode == MODE_WRITE) dir_b_in = req.write_data;
               REG_DDRA: if (req.mode == MODE_WRITE) dir_a_in = req.write_data;
               REG_T1CL, REG_T1LL: begin
                  if (req.mode == MODE_WRITE) t1_latch_in[7:0] = req.write_data;
                  else if (req.reg_addr == REG_T1CL) ifr_in[FL_T1] = 1'b0;
               end
               REG_T1CH: if (req.mode == MODE_WRITE) begin
                  t1_latch_in[15:8] = req.write_data;
                  t1_count_in = t1_latch_in;
                  ifr_in[FL_T1] = 1'b0;
                  run_in[RF_T1RUN] = 1'b1;
                  if (acr_ff[7:6] == 2'b10) out_b_in[7] = 1'b0;
               end
               REG_T1LH: if (req.mode == MODE_WRITE) begin
                  t1_latch_in[15:8] = req.write_data;
                  ifr_in[FL_T1] = 1'b0;
               end
               REG_T2CL: begin
                  if (req.mode == MODE_WRITE) t2_latch_in[7:0] = req.write_data;
                  else ifr_in[FL_T2] = 1'b0;
               end
               REG_T2CH: if (req.mode == MODE_WRITE) begin
                  t2_latch_in[15:8] = req.write_data;
                  t2_count_in = t2_latch_in;
                  ifr_in[FL_T2] = 1'b0;
                  run_in[RF_T2RUN] = 1'b1;
               end
               REG_SR: begin
                  if (req.mode == MODE_WRITE) sr_data_in = req.write_data;
                  sr_count_in = '0;
                  sr_timer_in = '0;
                  ifr_in[FL_SR] = 1'b0;
               end
               REG_ACR: if (req.mode == MODE_WRITE) begin
                  acr_in = req.write_data;
                  if (!req.write_data[6]) run_in[RF_T1RLD] = 1'b0;
               end
               REG_PCR: if (req.mode == MODE_WRITE) begin
                  pcr_in = req.write_data;
                  if (req.write_data[3:1] == HS_OUT_LOW) begin
                     lines_in[LINE_CA2] = 1'b0;
                     run_in[RF_CA2P] = 1'b0;
                  end else if (req.write_data[3:1] == HS_OUT_HI) begin
                     lines_in[LINE_CA2] = 1'b1;
                  end
                  if (req.write_data[7:5] == HS_OUT_LOW) begin
                     lines_in[LINE_CB2] = 1'b0;
                     run_in[RF_CB2P] = 1'b0;
                  end else if (req.write_data[7:5] == HS_OUT_HI) begin
                     lines_in[LINE_CB2] = 1'b1;
                  end
               end
               REG_IFR: if (req.mode == MODE_WRITE) begin
                  if (req.write_data[FL_CA1]) lat_a_in = in_a_ff;
                  if (req.write_data[FL_CB1]) lat_b_in = in_b_ff;
                  ifr_in = ifr_ff & ~req.write_data[6:0];
               end
               REG_IER: if (req.mode == MODE_WRITE) begin
                  if (req.write_data[7]) ier_in = ier_ff | req.write_data[6:0];
                  else ier_in = ier_ff & ~req.write_data[6:0];
               end
               default: if (req.mode == MODE_WRITE) out_a_in = req.write_data;
            endcase
         end
         MODE_TICK: if (req.tick_cycles) begin
            // end pending output pulses
            if (run_ff[RF_CA2P]) begin
               lines_in[LINE_CA2] = 1'b1;
               run_in[RF_CA2P] = 1'b0;
            end
            if (run_ff[RF_CB2P]) begin
               lines_in[LINE_CB2] = 1'b1;
               run_in[RF_CB2P] = 1'b0;
            end
            // timer 1
            if (!acr_ff[6]) begin
               if (run_ff[RF_T1RUN] && t1_count_ff == 16'h0000) begin
                  ifr_in[FL_T1] = 1'b1;
                  if (acr_ff[7]) out_b_in[7] = 1'b1;
                  run_in[RF_T1RUN] = 1'b0;
               end
               t1_count_in = t1_count_ff - 16'd1;
            end else if (run_ff[RF_T1RLD]) begin
               t1_count_in = t1_latch_ff;
               run_in[RF_T1RLD] = 1'b0;
            end else if (t1_count_ff == 16'h0000) begin
               t1_count_in = 16'hffff;
               ifr_in[FL_T1] = 1'b1;
               if (acr_ff[7]) out_b_in[7] = ~out_b_ff[7];
               run_in[RF_T1RLD] = 1'b1;
            end else begin
               t1_count_in = t1_count_ff - 16'd1;
            end
            // timer 2 in one-shot mode
            if (!acr_ff[5]) begin
               if (run_ff[RF_T2RUN] && t2_count_ff == 16'h0000) begin
                  ifr_in[FL_T2] = 1'b1;
                  run_in[RF_T2RUN] = 1'b0;
               end
               t2_count_in = t2_count_ff - 16'd1;
            end
            // shift register
            if (acr_ff[4:2] == SM_FREE || acr_ff[4:2] == SM_T2OUT) begin
               if (!(acr_ff[4:2] == SM_T2OUT && sr_count_ff == SR_FULL)) begin
                  t = $signed({2'b00, sr_timer_ff}) - 11'sd1;
                  // toggle the shift clock each time the shift timer runs out
                  for (int i = 0; i < 2; i++) begin
                     if (!stop && t <= 11'sd0) begin
                        t = t + $signed({2'b00, reload});
                        lines_in[LINE_CB1] = ~lines_in[LINE_CB1];
                        falling = ~lines_in[LINE_CB1];
                        if (falling) begin
                           lines_in[LINE_CB2] = sr_data_in[7];
                           sr_data_in = {sr_data_in[6:0], sr_data_in[7]};
                           if (acr_ff[4:2] == SM_FREE) begin
                              sr_count_in = {1'b0, sr_count_in[2:0] + 3'd1};
                           end else begin
                              sr_count_in = sr_count_in + 4'd1;
                              if (sr_count_in == SR_FULL) begin
                                 ifr_in[FL_SR] = 1'b1;
                                 t = '0;
                                 stop = 1'b1;
                              end
                           end
                        end
                     end
                  end
                  sr_timer_in = t[8:0];
               end
            end else if (acr_ff[4:2] == SM_PHI2) begin
               if (sr_count_ff != SR_FULL) begin
                  lines_in[LINE_CB1] = ~lines_ff[LINE_CB1];
                  if (lines_ff[LINE_CB1]) begin
                     lines_in[LINE_CB2] = sr_data_ff[7];
                     sr_data_in = {sr_data_ff[6:0], sr_data_ff[7]};
                     sr_count_in = sr_count_ff + 4'd1;
                     if (sr_count_in == SR_FULL) ifr_in[FL_SR] = 1'b1;
                  end
               end
            end else begin
               ifr_in[FL_SR] = 1'b0;
               sr_count_in = '0;
            end
         end
         MODE_LINE: begin
            case (req.line_select)
               LINE_CA1, LINE_CB1: begin
                  old = lines_ff[req.line_select];
                  if (req.line_select == LINE_CA1) begin
                     if ((!old && lv && pcr_ff[0]) || (old && !lv && !pcr_ff[0]))
                        ifr_in[FL_CA1] = 1'b1;
                  end else begin
                     if ((!old && lv && pcr_ff[4]) || (old && !lv && !pcr_ff[4]))
                        ifr_in[FL_CB1] = 1'b1;
                  end
                  lines_in[req.line_select] = lv;
               end
               default: begin
                  old = lines_ff[req.line_select];
                  hs = (req.line_select == LINE_CA2) ? pcr_ff[3:1] : pcr_ff[7:5];
                  if (!hs[2]) begin
                     if ((!hs[1] && old && !lv) || (hs[1] && !old && lv)) begin
                        if (req.line_select == LINE_CA2) ifr_in[FL_CA2] = 1'b1;
                        else ifr_in[FL_CB2] = 1'b1;
                     end
                     lines_in[req.line_select] = lv;
                  end
               end
            endcase
         end
         MODE_PORT: begin
            if (!req.port_select) begin
               in_a_in = (in_a_ff & ~req.port_mask) | (req.write_data & req.port_mask);
               if (!acr_ff[0] || !ifr_ff[FL_CA1]) lat_a_in = in_a_in;
            end else begin
               in_b_in = (in_b_ff & ~req.port_mask) | (req.write_data & req.port_mask);
               if (!acr_ff[1] || !ifr_ff[FL_CB1]) lat_b_in = in_b_in;
               // count falling edges on PB6
               if (acr_ff[5] && in_b_ff[6] && !in_b_in[6]) begin
                  t2_count_in = t2_count_ff - 16'd1;
                  if (run_ff[RF_T2RUN] && t2_count_in == 16'h0000) begin
                     ifr_in[FL_T2] = 1'b1;
                     run_in[RF_T2RUN] = 1'b0;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   // Result fields from the updated state
   assign rsp.read_data  = rd;
   assign rsp.irq        = |(ifr_in & ier_in);
   assign rsp.port_a_out = out_a_in & dir_a_in;
   assign rsp.port_b_out = out_b_in & dir_b_in;
   assign rsp.ca2_level  = lines_in[LINE_CA2];
   assign rsp.cb1_level  = lines_in[LINE_CB1];
   assign rsp.cb2_level  = lines_in[LINE_CB2];

   // Commit the state when the item advances
   always_ff @(posedge clock) begin
      if (reset) begin
         out_a_ff <= '0; out_b_ff <= '0; dir_a_ff <= '0; dir_b_ff <= '0;
         in_a_ff <= '0; in_b_ff <= '0; lat_a_ff <= '0; lat_b_ff <= '0;
         t1_latch_ff <= '0; t1_count_ff <= '0; t2_latch_ff <= '0; t2_count_ff <= '0;
         sr_data_ff <= '0; acr_ff <= '0; pcr_ff <= '0;
         ifr_ff <= '0; ier_ff <= '0; lines_ff <= '0; run_ff <= '0;
         sr_count_ff <= '0; sr_timer_ff <= '0;
      end else if (step) begin
         out_a_ff <= out_a_in; out_b_ff <= out_b_in;
         dir_a_ff <= dir_a_in; dir_b_ff <= dir_b_in;
         in_a_ff <= in_a_in; in_b_ff <= in_b_in;
         lat_a_ff <= lat_a_in; lat_b_ff <= lat_b_in;
         t1_latch_ff <= t1_latch_in; t1_count_ff <= t1_count_in;
         t2_latch_ff <= t2_latch_in; t2_count_ff <= t2_count_in;
         sr_data_ff <= sr_data_in; acr_ff <= acr_in; pcr_ff <= pcr_in;
         ifr_ff <= ifr_in; ier_ff <= ier_in; lines_ff <= lines_in; run_ff <= run_in;
         sr_count_ff <= sr_count_in; sr_timer_ff <= sr_timer_in;
      end
   end

endmodule

@@ sv/versatile_interface_adapter.sv @@
// ----------------------------------------------------------------------------
// versatile_interface_adapter
// 6522-style interface adapter with a valid/ready item channel.
// ----------------------------------------------------------------------------
// Takes one item per clock unless the result side stalls, and returns one
// result per item. The item is held in an input register, the core applies it
// to the register file, and the result lands in an output register when that
// register is free or its result is being taken.
// Both stages advance together, so a stalled result only holds the input side
// once both registers are full.
module versatile_interface_adapter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  vai_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output vai_pkg::rsp_type rsp_data
);
   import vai_pkg::*;

   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   rsp_type core_rsp;
   logic    advance;

   // Move the held item into the result register when it is free or its result is being taken
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   vai_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_data_ff),
      .rsp   (core_rsp)
   );

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // Result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= core_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

@@ sv/vai_checker.sv @@
// ----------------------------------------------------------------------------
// vai_checker
// Port-level checks of the interface adapter, bound to the top level.
// ----------------------------------------------------------------------------
`include "versatile_interface_adapter_assert.svh"

module vai_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input vai_pkg::rsp_type rsp_data
);
   import vai_pkg::*;

   // a stalled result holds
   `VIA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // input backs up only behind a stalled result
   `VIA_ASSERT_NOW(a_ready_low, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // reset empties both stages
   `VIA_ASSERT_ALWAYS_NEXT(a_reset_empty, clock, reset, !rsp_valid && req_ready)

   // an empty result side never blocks the input
   `VIA_ASSERT_NOW(a_empty_ready, clock, reset, !rsp_valid, req_ready)

endmodule

bind versatile_interface_adapter vai_checker u_vai_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ tb/via_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// via_checker
// Watches both item channels of the interface adapter, predicts each result
// from its own copy of the register state, compares it and prints the fields on a mismatch.
// ----------------------------------------------------------------------------
module via_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  vai_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  vai_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               pending_count
);
   import vai_pkg::*;

   // adapter state
   logic [7:0]  ora, orb, ddra, ddrb, pin_a, pin_b, lat_a, lat_b;
   logic [15:0] t1_latch, t1_count, t2_latch, t2_count;
   logic [7:0]  sr_data, acr, pcr, ifr;
   logic [6:0]  ier;
   logic [3:0]  lines;   // CA1 CA2 CB1 CB2 from bit 0
   logic [4:0]  runs;
   logic [3:0]  sr_count;
   logic [8:0]  sr_timer;

   rsp_type result_queue[$];

   localparam int L_CA1 = 0, L_CA2 = 1, L_CB1 = 2, L_CB2 = 3;

   function automatic void clear_state();
      ora = 0; orb = 0; ddra = 0; ddrb = 0; pin_a = 0; pin_b = 0; lat_a = 0; lat_b = 0;
      t1_latch = 0; t1_count = 0; t2_latch = 0; t2_count = 0;
      sr_data = 0; acr = 0; pcr = 0; ifr = 0; ier = 0; lines = 0; runs = 0;
      sr_count = 0; sr_timer = 0;
   endfunction

   function automatic void raise_flag(int b);
      ifr[b] = 1'b1;
      ifr[7] = 1'b0;
   endfunction

   // clearing CA1/CB1 reloads the matching port latch
   function automatic void drop_flags(logic [7:0] m);
      if (m[FL_CA1]) lat_a = pin_a;
      if (m[FL_CB1]) lat_b = pin_b;
      ifr = ifr & ~m & 8'h7f;
   endfunction

   function automatic logic irq_now();
      return |(ifr[6:0] & ier);
   endfunction

   function automatic void touch_port_b();
      drop_flags(8'(1 << FL_CB1));
      case (pcr[7:5])
         HS_IN_NEG, HS_IN_POS: drop_flags(8'(1 << FL_CB2));
         HS_OUT_PLS: begin
            runs[RF_CB2P] = 1'b1;
            lines[L_CB2] = 1'b0;
         end
         HS_OUT_HS: lines[L_CB2] = 1'b0;
         default: ;
      endcase
   endfunction

   function automatic void touch_port_a();
      drop_flags(8'(1 << FL_CA1));
      case (pcr[3:1])
         HS_IN_NEG, HS_IN_POS: drop_flags(8'(1 << FL_CA2));
         HS_OUT_PLS: begin
            runs[RF_CA2P] = 1'b1;
            lines[L_CA2] = 1'b0;
         end
         HS_OUT_HS: lines[L_CA2] = 1'b0;
         default: ;
      endcase
   endfunction

   // toggle the shift clock; report a falling edge after shifting one bit out
   function automatic logic shift_clock();
      logic c, d;
      c = ~lines[L_CB1];
      lines[L_CB1] = c;
      if (c) return 1'b0;
      d = sr_data[7];
      lines[L_CB2] = d;
      sr_data = {sr_data[6:0], d};
      return 1'b1;
   endfunction

   function automatic void advance_clock();
      logic [2:0] sm;
      int t;
      sm = acr[4:2];
      if (runs[RF_CA2P]) begin
         lines[L_CA2] = 1'b1;
         runs[RF_CA2P] = 1'b0;
      end
      if (runs[RF_CB2P]) begin
         lines[L_CB2] = 1'b1;
         runs[RF_CB2P] = 1'b0;
      end
      // timer 1
      if (!acr[6]) begin
         if (runs[RF_T1RUN] && t1_count == 0) begin
            raise_flag(FL_T1);
            if (acr[7]) orb[7] = 1'b1;
            runs[RF_T1RUN] = 1'b0;
         end
         t1_count = t1_count - 16'd1;
      end else if (runs[RF_T1RLD]) begin
         t1_count = t1_latch;
         runs[RF_T1RLD] = 1'b0;
      end else if (t1_count == 0) begin
         t1_count = 16'hffff;
         raise_flag(FL_T1);
         if (acr[7]) orb[7] = ~orb[7];
         runs[RF_T1RLD] = 1'b1;
      end else begin
         t1_count = t1_count - 16'd1;
      end
      // timer 2 in one-shot mode
      if (!acr[5]) begin
         if (runs[RF_T2RUN] && t2_count == 0) begin
            raise_flag(FL_T2);
            runs[RF_T2RUN] = 1'b0;
         end
         t2_count = t2_count - 16'd1;
      end
      // shift register
      if (sm == SM_FREE || sm == SM_T2OUT) begin
         if (sm == SM_T2OUT && sr_count == SR_FULL) return;
         t = int'(sr_timer) - 1;
         while (t <= 0) begin
            t += int'(t2_latch[7:0]) + 1;
            if (shift_clock()) begin
               if (sm == SM_FREE) begin
                  sr_count = (sr_count + 4'd1) & 4'd7;
               end else begin
                  sr_count++;
                  if (sr_count == SR_FULL) begin
                     raise_flag(FL_SR);
                     t = 0;
                     break;
                  end
               end
            end
         end
         sr_timer = 9'(t);
      end else if (sm == SM_PHI2) begin
         if (sr_count != SR_FULL && shift_clock()) begin
            sr_count++;
            if (sr_count == SR_FULL) raise_flag(FL_SR);
         end
      end else begin
         drop_flags(8'(1 << FL_SR));
         sr_count = 0;
      end
   endfunction

   function automatic void write_register(logic [3:0] a, logic [7:0] d);
      case (a)
         REG_ORB: begin
            orb = d;
            touch_port_b();
         end
         REG_ORA: begin
            ora = d;
            touch_port_a();
         end
         REG_DDRB: ddrb = d;
         REG_DDRA: ddra = d;
         REG_T1CL, REG_T1LL: t1_latch[7:0] = d;
         REG_T1CH: begin
            t1_latch[15:8] = d;
            t1_count = t1_latch;
            drop_flags(8'(1 << FL_T1));
            runs[RF_T1RUN] = 1'b1;
            if (acr[7:6] == 2'b10) orb[7] = 1'b0;
         end
         REG_T1LH: begin
            t1_latch[15:8] = d;
            drop_flags(8'(1 << FL_T1));
         end
         REG_T2CL: t2_latch[7:0] = d;
         REG_T2CH: begin
            t2_latch[15:8] = d;
            t2_count = t2_latch;
            drop_flags(8'(1 << FL_T2));
            runs[RF_T2RUN] = 1'b1;
         end
         REG_SR: begin
            sr_data = d;
            sr_count = 0;
            sr_timer = 0;
            drop_flags(8'(1 << FL_SR));
         end
         REG_ACR: begin
            acr = d;
            if (!d[6]) runs[RF_T1RLD] = 1'b0;
         end
         REG_PCR: begin
            pcr = d;
            if (d[3:1] == HS_OUT_LOW) begin
               lines[L_CA2] = 1'b0;
               runs[RF_CA2P] = 1'b0;
            end else if (d[3:1] == HS_OUT_HI) begin
               lines[L_CA2] = 1'b1;
            end
            if (d[7:5] == HS_OUT_LOW) begin
               lines[L_CB2] = 1'b0;
               runs[RF_CB2P] = 1'b0;
            end else if (d[7:5] == HS_OUT_HI) begin
               lines[L_CB2] = 1'b1;
            end
         end
         REG_IFR: drop_flags(d & 8'h7f);
         REG_IER: begin
            if (d[7]) ier = ier | d[6:0];
            else ier = ier & ~d[6:0];
         end
         default: ora = d;
      endcase
   endfunction

   function automatic logic [7:0] read_register(logic [3:0] a);
      logic [7:0] r;
      case (a)
         REG_ORB: begin
            r = (orb & ddrb) | (lat_b & ~ddrb);
            touch_port_b();
         end
         REG_ORA: begin
            r = (ora & ddra) | (lat_a & ~ddra);
            touch_port_a();
         end
         REG_DDRB: r = ddrb;
         REG_DDRA: r = ddra;
         REG_T1CL: begin
            drop_flags(8'(1 << FL_T1));
            r = t1_count[7:0];
         end
         REG_T1CH: r = t1_count[15:8];
         REG_T1LL: r = t1_latch[7:0];
         REG_T1LH: r = t1_latch[15:8];
         REG_T2CL: begin
            drop_flags(8'(1 << FL_T2));
            r = t2_count[7:0];
         end
         REG_T2CH: r = t2_count[15:8];
         REG_SR: begin
            sr_count = 0;
            sr_timer = 0;
            drop_flags(8'(1 << FL_SR));
            r = sr_data;
         end
         REG_ACR: r = acr;
         REG_PCR: r = pcr;
         REG_IFR: r = {irq_now(), ifr[6:0]};
         REG_IER: r = {1'b1, ier};
         default: r = (ora & ddra) | (lat_a & ~ddra);
      endcase
      return r;
   endfunction

   function automatic void change_line(logic [1:0] sel, logic lv);
      logic old, pos;
      logic [2:0] hs;
      int b;
      if (sel == LINE_CA1 || sel == LINE_CB1) begin
         b = (sel == LINE_CA1) ? L_CA1 : L_CB1;
         pos = (sel == LINE_CA1) ? pcr[0] : pcr[4];
         old = lines[b];
         if ((!old && lv && pos) || (old && !lv && !pos))
            raise_flag(sel == LINE_CA1 ? FL_CA1 : FL_CB1);
         lines[b] = lv;
         return;
      end
      b = (sel == LINE_CA2) ? L_CA2 : L_CB2;
      hs = (sel == LINE_CA2) ? pcr[3:1] : pcr[7:5];
      old = lines[b];
      if (hs[2]) return;
      if ((!hs[1] && old && !lv) || (hs[1] && !old && lv))
         raise_flag(sel == LINE_CA2 ? FL_CA2 : FL_CB2);
      lines[b] = lv;
   endfunction

   function automatic void drive_port(logic sel, logic [7:0] mask, logic [7:0] d);
      logic last6;
      if (!sel) begin
         pin_a = (pin_a & ~mask) | (d & mask);
         if (!acr[0] || !ifr[FL_CA1]) lat_a = pin_a;
         return;
      end
      last6 = pin_b[6];
      pin_b = (pin_b & ~mask) | (d & mask);
      if (!acr[1] || !ifr[FL_CB1]) lat_b = pin_b;
      // pulse counting on a falling PB6
      if (!acr[5] || !last6 || pin_b[6]) return;
      t2_count = t2_count - 16'd1;
      if (runs[RF_T2RUN] && t2_count == 0) begin
         raise_flag(FL_T2);
         runs[RF_T2RUN] = 1'b0;
      end
   endfunction

   function automatic rsp_type apply_item(req_type q);
      rsp_type r;
      r.read_data = 8'h00;
      case (q.mode)
         MODE_WRITE: write_register(q.reg_addr, q.write_data);
         MODE_READ:  r.read_data = read_register(q.reg_addr);
         MODE_TICK:  if (q.tick_cycles) advance_clock();
         MODE_LINE:  change_line(q.line_select, q.write_data[0]);
         MODE_PORT:  drive_port(q.port_select, q.port_mask, q.write_data);
         default: ;
      endcase
      r.irq = irq_now();
      r.port_a_out = ora & ddra;
      r.port_b_out = orb & ddrb;
      r.ca2_level = lines[L_CA2];
      r.cb1_level = lines[L_CB1];
      r.cb2_level = lines[L_CB2];
      return r;
   endfunction

   // predict on accepted items, compare on accepted results
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         clear_state();
         result_queue.delete();
         fail_count <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (result_queue.size() == 0) begin
               fail_count <= fail_count + 1;
               if (fail_count < 10)
                  $display("mismatch: unexpected result %h", rsp_data);
            end else begin
               want = result_queue.pop_front();
               if (rsp_data !== want) begin
                  fail_count <= fail_count + 1;
                  if (fail_count < 10)
                     $display("mismatch: rd %h/%h irq %b/%b pa %h/%h pb %h/%h lines %b%b%b/%b%b%b",
                        want.read_data, rsp_data.read_data, want.irq, rsp_data.irq,
                        want.port_a_out, rsp_data.port_a_out, want.port_b_out,
                        rsp_data.port_b_out, want.ca2_level, want.cb1_level,
                        want.cb2_level, rsp_data.ca2_level, rsp_data.cb1_level,
                        rsp_data.cb2_level);
               end
            end
         end
         if (req_valid && req_ready) result_queue.push_back(apply_item(req_data));
      end
      pending_count <= result_queue.size();
   end

endmodule

@@ tb/tb_versatile_interface_adapter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_versatile_interface_adapter
// Drives directed and random bus, tick, line and port items into the adapter
// with random gaps on both sides; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_versatile_interface_adapter;
   import vai_pkg::*;

   localparam int RANDOM_ITEMS = 550;
   localparam int IDLE_LIMIT   = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count, pending_count;
   logic    hold_rsp = 1'b0;
   int      idle_cycles = 0;

   versatile_interface_adapter uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   via_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always #6 clock = ~clock;

   function automatic int gap_length();
      if ($urandom_range(9) < 3) return 0;
      if ($urandom_range(19) == 0) return $urandom_range(40, 12);
      return $urandom_range(3);
   endfunction

   // offer one item at the falling edge and hold it until accepted
   task automatic send_item(req_type q);
      int g;
      g = gap_length();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_data <= q;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic req_type make_item(logic [2:0] m, logic [3:0] a, logic [7:0] d);
      req_type q;
      q = '0;
      q.mode = m;
      q.reg_addr = a;
      q.write_data = d;
      q.port_mask = 8'hff;
      q.tick_cycles = 1'b1;
      return q;
   endfunction

   // fully random item, weighted toward ticks and register traffic
   function automatic req_type random_item();
      req_type q;
      int k;
      q = req_type'({$urandom, $urandom});
      k = $urandom_range(99);
      if (k < 30) q.mode = MODE_TICK;
      else if (k < 50) q.mode = MODE_WRITE;
      else if (k < 70) q.mode = MODE_READ;
      else if (k < 83) q.mode = MODE_LINE;
      else if (k < 97) q.mode = MODE_PORT;
      else q.mode = 3'($urandom_range(7, 5));
      if (q.mode == MODE_TICK && $urandom_range(9) != 0) q.tick_cycles = 1'b1;
      // keep timer high and low bytes small so counts expire within a run
      if (q.mode == MODE_WRITE && (q.reg_addr == REG_T1CH || q.reg_addr == REG_T1LH ||
          q.reg_addr == REG_T2CH) && $urandom_range(3) != 0)
         q.write_data = 8'h00;
      if (q.mode == MODE_WRITE && (q.reg_addr == REG_T1CL || q.reg_addr == REG_T2CL ||
          q.reg_addr == REG_T1LL) && $urandom_range(3) != 0)
         q.write_data = 8'($urandom_range(12));
      return q;
   endfunction

   // drop valid and wait until every result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0 || rsp_valid);
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int g;
      logic hold_taken;
      hold_taken = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp && !hold_taken) begin
            hold_taken = 1'b1;
            rsp_ready <= 1'b0;
            repeat (60) @(negedge clock);
         end
         g = $urandom_range(3) == 0 ? gap_length() : 0;
         if (g > 0) begin
            rsp_ready <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(negedge clock);
      end
   end

   // watchdog on cycles with no acceptance
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      req_type q;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, a selection of registers, control lines and latching
      send_item(make_item(MODE_WRITE, REG_DDRA, 8'hff));
      send_item(make_item(MODE_WRITE, REG_DDRB, 8'h0f));
      send_item(make_item(MODE_WRITE, REG_ORA, 8'hff));
      send_item(make_item(MODE_WRITE, REG_ORB, 8'ha5));
      send_item(make_item(MODE_WRITE, REG_IER, 8'hff));
      send_item(make_item(MODE_WRITE, REG_ACR, 8'hc3));
      send_item(make_item(MODE_WRITE, REG_T1CL, 8'h02));
      send_item(make_item(MODE_WRITE, REG_T1CH, 8'h00));
      repeat (5) send_item(make_item(MODE_TICK, REG_ORB, 8'h00));
      q = make_item(MODE_PORT, REG_ORB, 8'hff);
      q.port_select = 1'b1;
      send_item(q);
      send_item(make_item(MODE_LINE, REG_ORB, 8'h01));
      q = make_item(MODE_LINE, REG_ORB, 8'h00);
      q.line_select = LINE_CB1;
      send_item(q);
      q = make_item(MODE_PORT, REG_ORB, 8'h00);
      q.port_select = 1'b1;
      q.port_mask = 8'h55;
      send_item(q);
      send_item(make_item(MODE_READ, REG_ORB, 8'h00));
      send_item(make_item(MODE_READ, REG_IFR, 8'h00));
      send_item(make_item(MODE_WRITE, REG_PCR, 8'hee));
      send_item(make_item(MODE_WRITE, REG_ACR, 8'h18));
      send_item(make_item(MODE_WRITE, REG_SR, 8'h81));
      q = make_item(MODE_TICK, REG_ORB, 8'h00);
      q.tick_cycles = 1'b0;
      send_item(q);
      send_item(make_item(3'd7, REG_ORANH, 8'hff));
      send_item(make_item(MODE_READ, REG_ORANH, 8'h00));

      // sender pauses until everything has come back
      wait_drained();

      // receiver holds off while items keep coming
      hold_rsp <= 1'b1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         q = random_item();
         send_item(q);
         if (i == 250) wait_drained();
      end

      wait_drained();
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
